>>> hdl/ptsch_pkg.sv
// shared codes, widths and defaults for the periodic task scheduler
package ptsch_pkg;

  localparam int unsigned MAX_TASKS_DEF = 16;
  localparam int unsigned TICK_MS_DEF   = 10;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned HANDLE_W = 8;
  localparam int unsigned MS_W     = 32;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned RUNS_W   = 8;

  localparam logic [REQ_W-1:0] REQ_ADD      = 3'd0;
  localparam logic [REQ_W-1:0] REQ_TICK     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DISPATCH = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DELETE   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  localparam logic [RUNS_W-1:0] RUNS_MAX = 8'hFF;

endpackage

>>> hdl/periodic_task_scheduler_core.sv
// periodic task scheduler: task table in one synchronous memory, walked by a sequencer
//
// Input channel (in_valid_i / in_ready_o) carries one request word: add, tick,
// dispatch, delete or clear. One request is worked on at a time; in_ready_o is
// high while the sequencer is idle, also while a result word still waits.
// Output channel (out_valid_o / out_ready_i) carries result words from a
// single output register. Dispatch gives one word per task with a pending run
// (last_o on the final one), or one empty word; every other request gives one.
// Add runs two reciprocal divisions by TICK_MS, one for the delay and one for
// the period, unless the table is full. Tick walks every entry, delete walks
// the entries after index i, and clear and the other codes need no walk.
// Dispatch makes a counting pass, then an update pass unless nothing is pending,
// one entry a cycle while no run word stalls, both bound by the single memory read port.
// The table memory has one write and one read port; a walk writes entry w
// while it reads entry s+1 with w <= s, so accesses never meet the same entry.
// Reset empties the table at once; entries are never read before written.
// A stalled receiver holds the dispatch walk on the entry whose word waits.
module periodic_task_scheduler_core #(
  parameter int unsigned MAX_TASKS = ptsch_pkg::MAX_TASKS_DEF,
  parameter int unsigned TICK_MS   = ptsch_pkg::TICK_MS_DEF,
  localparam int unsigned CW       = $clog2(MAX_TASKS + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [ptsch_pkg::REQ_W-1:0]      req_type_i,
  input  logic [ptsch_pkg::HANDLE_W-1:0]   task_handle_i,
  input  logic [ptsch_pkg::MS_W-1:0]       delay_ms_i,
  input  logic [ptsch_pkg::MS_W-1:0]       period_ms_i,
  input  logic [ptsch_pkg::IDX_W-1:0]      task_index_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             run_valid_o,
  output logic [ptsch_pkg::HANDLE_W-1:0]   run_handle_o,
  output logic                             last_o,
  output logic [ptsch_pkg::STATUS_W-1:0]   status_o,
  output logic [CW-1:0]                    task_count_o
);

  localparam int unsigned AW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned XW  = (CW > ptsch_pkg::IDX_W) ? CW : ptsch_pkg::IDX_W;
  localparam int unsigned TW  = $clog2(TICK_MS + 1);
  localparam int unsigned MW  = ptsch_pkg::MS_W;
  localparam logic [MW-1:0] RECIP  = MW'(64'h0000_0000_FFFF_FFFF / TICK_MS);
  localparam logic [MW-1:0] TICK_V = MW'(TICK_MS);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_TASKS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV1 = 3'd1;
  localparam logic [2:0] ST_DIV2 = 3'd2;
  localparam logic [2:0] ST_DIV3 = 3'd3;
  localparam logic [2:0] ST_SCAN = 3'd4;
  localparam logic [2:0] ST_WALK = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  typedef struct packed {
    logic [ptsch_pkg::HANDLE_W-1:0] handle;
    logic [MW-1:0]                  delay;
    logic [MW-1:0]                  period;
    logic [ptsch_pkg::RUNS_W-1:0]   runs;
  } entry_t;

  entry_t mem [MAX_TASKS];
  entry_t rd_q;
  logic   rd_en;
  logic [AW-1:0] rd_addr;
  logic   wr_en;
  logic [AW-1:0] wr_addr;
  entry_t wr_data;

  logic [2:0] state_q, state_d;
  logic [ptsch_pkg::REQ_W-1:0] op_q, op_d;
  logic [CW-1:0] used_q, used_d;
  logic [CW-1:0] s_q, s_d;
  logic [CW-1:0] w_q, w_d;
  logic [CW-1:0] last_s_q, last_s_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [CW-1:0] fin_cnt_q, fin_cnt_d;
  logic          any_q, any_d;
  logic          sel_q, sel_d;
  logic [ptsch_pkg::STATUS_W-1:0] status_q, status_d;

  logic [ptsch_pkg::HANDLE_W-1:0] hnd_q, hnd_d;
  logic [MW-1:0] dly_q, dly_d;
  logic [MW-1:0] per_q, per_d;
  logic [MW-1:0] qe_q, qe_d;
  logic [MW-1:0] mul2_q, mul2_d;
  logic [MW-1:0] dq_q, dq_d;

  logic                           out_valid_q;
  logic                           out_load;
  logic                           ov_run, or_last;
  logic [ptsch_pkg::HANDLE_W-1:0] ov_handle;
  logic [ptsch_pkg::STATUS_W-1:0] ov_status;
  logic [CW-1:0]                  ov_count;
  logic                           run_q, last_q;
  logic [ptsch_pkg::HANDLE_W-1:0] handle_q;
  logic [ptsch_pkg::STATUS_W-1:0] ostat_q;
  logic [CW-1:0]                  count_q;

  logic            out_free;
  logic [MW-1:0]   div_x;
  logic [2*MW-1:0] prod1;
  logic [MW+TW-1:0] prod2;
  logic [MW-1:0]   div_r;
  logic [MW-1:0]   div_q;
  logic [XW-1:0]   idx_x;
  logic [XW-1:0]   used_x;
  logic [XW-1:0]   idx_nx;
  logic [CW-1:0]   s_nx;
  logic [CW-1:0]   w_nx;
  logic [CW-1:0]   rem_nx;
  logic [CW-1:0]   last_nx;
  logic            any_nx;
  logic            emit;
  logic            keep;
  logic            stall;
  entry_t          ne;

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  assign div_x  = sel_q ? per_q : dly_q;
  assign prod1  = (2*MW)'(div_x) * (2*MW)'(RECIP);
  assign prod2  = (MW+TW)'(qe_q) * (MW+TW)'(TICK_MS);
  assign div_r  = div_x - mul2_q;
  assign div_q  = qe_q + MW'(div_r >= TICK_V);

  assign idx_x  = XW'(task_index_i);
  assign used_x = XW'(used_q);
  assign idx_nx = idx_x + XW'(1);
  assign s_nx   = s_q + CW'(1);
  assign emit   = (rd_q.runs != '0);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    used_d    = used_q;
    s_d       = s_q;
    w_d       = w_q;
    last_s_d  = last_s_q;
    rem_d     = rem_q;
    fin_cnt_d = fin_cnt_q;
    any_d     = any_q;
    sel_d     = sel_q;
    status_d  = status_q;
    hnd_d     = hnd_q;
    dly_d     = dly_q;
    per_d     = per_q;
    qe_d      = qe_q;
    mul2_d    = mul2_q;
    dq_d      = dq_q;
    rd_en     = 1'b0;
    rd_addr   = s_nx[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = w_q[AW-1:0];
    wr_data   = rd_q;
    out_load  = 1'b0;
    ov_run    = 1'b0;
    ov_handle = '0;
    or_last   = 1'b1;
    ov_status = status_q;
    ov_count  = used_q;
    any_nx    = any_q | emit;
    last_nx   = emit ? s_q : last_s_q;
    rem_nx    = rem_q + CW'(emit && (rd_q.period == '0));
    keep      = 1'b1;
    stall     = 1'b0;
    w_nx      = w_q;
    ne        = rd_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d     = req_type_i;
          hnd_d    = task_handle_i;
          dly_d    = delay_ms_i;
          per_d    = period_ms_i;
          status_d = ptsch_pkg::STATUS_OK;
          state_d  = ST_DONE;
          case (req_type_i)
            ptsch_pkg::REQ_ADD: begin
              if (used_q == FULL_CNT) begin
                status_d = ptsch_pkg::STATUS_FULL;
              end else begin
                sel_d   = 1'b0;
                state_d = ST_DIV1;
              end
            end
            ptsch_pkg::REQ_TICK: begin
              if (used_q != '0) begin
                rd_en   = 1'b1;
                rd_addr = '0;
                s_d     = '0;
                w_d     = '0;
                state_d = ST_WALK;
              end
            end
            ptsch_pkg::REQ_DISPATCH: begin
              if (used_q != '0) begin
                rd_en   = 1'b1;
                rd_addr = '0;
                s_d     = '0;
                rem_d   = '0;
                any_d   = 1'b0;
                state_d = ST_SCAN;
              end
            end
            ptsch_pkg::REQ_DELETE: begin
              if (idx_x >= used_x) begin
                status_d = ptsch_pkg::STATUS_RANGE;
              end else if (idx_nx < used_x) begin
                rd_en   = 1'b1;
                rd_addr = AW'(idx_nx);
                s_d     = CW'(idx_nx);
                w_d     = CW'(idx_x);
                state_d = ST_WALK;
              end else begin
                used_d = used_q - CW'(1);
              end
            end
            ptsch_pkg::REQ_CLEAR: begin
              used_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_DIV1: begin
        qe_d    = prod1[2*MW-1:MW];
        state_d = ST_DIV2;
      end

      ST_DIV2: begin
        mul2_d  = prod2[MW-1:0];
        state_d = ST_DIV3;
      end

      ST_DIV3: begin
        if (!sel_q) begin
          dq_d    = div_q;
          sel_d   = 1'b1;
          state_d = ST_DIV1;
        end else begin
          wr_en          = 1'b1;
          wr_addr        = used_q[AW-1:0];
          wr_data.handle = hnd_q;
          wr_data.delay  = dq_q;
          wr_data.period = div_q;
          wr_data.runs   = '0;
          used_d         = used_q + CW'(1);
          state_d        = ST_DONE;
        end
      end

      // counting pass: final table size and position of the last run
      ST_SCAN: begin
        if (s_nx < used_q) begin
          rd_en    = 1'b1;
          s_d      = s_nx;
          any_d    = any_nx;
          last_s_d = last_nx;
          rem_d    = rem_nx;
        end else if (!any_nx) begin
          state_d = ST_DONE;
        end else begin
          fin_cnt_d = used_q - rem_nx;
          last_s_d  = last_nx;
          rd_en     = 1'b1;
          rd_addr   = '0;
          s_d       = '0;
          w_d       = '0;
          state_d   = ST_WALK;
        end
      end

      ST_WALK: begin
        case (op_q)
          ptsch_pkg::REQ_TICK: begin
            if (rd_q.delay != '0) begin
              ne.delay = rd_q.delay - MW'(1);
            end else begin
              ne.delay = rd_q.period;
              if (rd_q.runs != ptsch_pkg::RUNS_MAX) begin
                ne.runs = rd_q.runs + ptsch_pkg::RUNS_W'(1);
              end
            end
          end
          ptsch_pkg::REQ_DISPATCH: begin
            if (emit) begin
              stall   = !out_free;
              ne.runs = rd_q.runs - ptsch_pkg::RUNS_W'(1);
              keep    = (rd_q.period != '0);
            end
          end
          default: begin
          end
        endcase
        if (!stall) begin
          if (op_q == ptsch_pkg::REQ_DISPATCH && emit) begin
            out_load  = 1'b1;
            ov_run    = 1'b1;
            ov_handle = rd_q.handle;
            or_last   = (s_q == last_s_q);
            ov_status = ptsch_pkg::STATUS_OK;
            ov_count  = fin_cnt_q;
          end
          if (keep) begin
            wr_en   = 1'b1;
            wr_data = ne;
            w_nx    = w_q + CW'(1);
          end
          if (s_nx < used_q) begin
            rd_en = 1'b1;
            s_d   = s_nx;
            w_d   = w_nx;
          end else begin
            used_d  = w_nx;
            state_d = (op_q == ptsch_pkg::REQ_DISPATCH) ? ST_IDLE : ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // task table, synchronous read with registered data
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= ptsch_pkg::REQ_ADD;
      used_q      <= '0;
      s_q         <= '0;
      w_q         <= '0;
      last_s_q    <= '0;
      rem_q       <= '0;
      fin_cnt_q   <= '0;
      any_q       <= 1'b0;
      sel_q       <= 1'b0;
      status_q    <= ptsch_pkg::STATUS_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      used_q    <= used_d;
      s_q       <= s_d;
      w_q       <= w_d;
      last_s_q  <= last_s_d;
      rem_q     <= rem_d;
      fin_cnt_q <= fin_cnt_d;
      any_q     <= any_d;
      sel_q     <= sel_d;
      status_q  <= status_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hnd_q  <= hnd_d;
    dly_q  <= dly_d;
    per_q  <= per_d;
    qe_q   <= qe_d;
    mul2_q <= mul2_d;
    dq_q   <= dq_d;
    if (out_load) begin
      run_q    <= ov_run;
      handle_q <= ov_handle;
      last_q   <= or_last;
      ostat_q  <= ov_status;
      count_q  <= ov_count;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign run_valid_o  = run_q;
  assign run_handle_o = handle_q;
  assign last_o       = last_q;
  assign status_o     = ostat_q;
  assign task_count_o = count_q;

endmodule

>>> hdl/ptsch_checker.sv
// port-level checks for the periodic task scheduler, bound to the top level
module ptsch_checker #(
  parameter int unsigned CW = 5
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic                           run_valid_o,
  input logic [ptsch_pkg::HANDLE_W-1:0] run_handle_o,
  input logic                           last_o,
  input logic [ptsch_pkg::STATUS_W-1:0] status_o,
  input logic [CW-1:0]                  task_count_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(run_handle_o)
      && $stable(last_o) && $stable(task_count_o))
    else $error("result word changed while stalled");

  // a word without a run closes its request and carries no handle
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_valid_o |-> last_o && (run_handle_o == '0))
    else $error("empty result word not final or has a handle");

  // an error status never comes with a dispatched run
  a_err_no_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ptsch_pkg::STATUS_OK) |-> !run_valid_o)
    else $error("error status on a run word");

  // an accepted request keeps the sequencer busy in the cycle after
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while the previous one is still at work");

endmodule

bind periodic_task_scheduler_core ptsch_checker #(.CW(CW)) u_ptsch_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .run_valid_o (run_valid_o),
  .run_handle_o(run_handle_o),
  .last_o      (last_o),
  .status_o    (status_o),
  .task_count_o(task_count_o)
);

>>> verif/periodic_task_scheduler_core_tb.sv
// testbench for the periodic task scheduler core: directed table, random traffic, scoreboard
`timescale 1ns / 1ps

module periodic_task_scheduler_core_tb;

  localparam int unsigned CNT_W       = $clog2(ptsch_pkg::MAX_TASKS_DEF + 1);
  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned RAND_ITEMS  = 190;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DIR_N       = 23;

  // request codes the block ignores
  localparam logic [ptsch_pkg::REQ_W-1:0] REQ_RSVD_LO = 3'd5;
  localparam logic [ptsch_pkg::REQ_W-1:0] REQ_RSVD_MID = 3'd6;
  localparam logic [ptsch_pkg::REQ_W-1:0] REQ_RSVD_HI = 3'd7;

  typedef struct packed {
    logic                           run_valid;
    logic [ptsch_pkg::HANDLE_W-1:0] run_handle;
    logic                           last;
    logic [ptsch_pkg::STATUS_W-1:0] status;
    logic [CNT_W-1:0]               count;
  } reply_t;

  typedef struct packed {
    logic [ptsch_pkg::REQ_W-1:0]    req;
    logic [ptsch_pkg::HANDLE_W-1:0] handle;
    logic [ptsch_pkg::MS_W-1:0]     delay;
    logic [ptsch_pkg::MS_W-1:0]     period;
    logic [ptsch_pkg::IDX_W-1:0]    index;
    logic                           typed;
    reply_t                         want;
  } stim_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_e;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           in_valid_i    = 1'b0;
  logic [ptsch_pkg::REQ_W-1:0]    req_type_i    = ptsch_pkg::REQ_CLEAR;
  logic [ptsch_pkg::HANDLE_W-1:0] task_handle_i = '0;
  logic [ptsch_pkg::MS_W-1:0]     delay_ms_i    = '0;
  logic [ptsch_pkg::MS_W-1:0]     period_ms_i   = '0;
  logic [ptsch_pkg::IDX_W-1:0]    task_index_i  = '0;
  logic                           out_ready_i   = 1'b0;
  logic                           in_ready_o;
  logic                           out_valid_o;
  logic                           run_valid_o;
  logic [ptsch_pkg::HANDLE_W-1:0] run_handle_o;
  logic                           last_o;
  logic [ptsch_pkg::STATUS_W-1:0] status_o;
  logic [CNT_W-1:0]               task_count_o;

  // shadow copy of the task table
  logic [ptsch_pkg::HANDLE_W-1:0] tbl_handle [ptsch_pkg::MAX_TASKS_DEF];
  logic [ptsch_pkg::MS_W-1:0]     tbl_delay  [ptsch_pkg::MAX_TASKS_DEF];
  logic [ptsch_pkg::MS_W-1:0]     tbl_period [ptsch_pkg::MAX_TASKS_DEF];
  logic [ptsch_pkg::RUNS_W-1:0]   tbl_runs   [ptsch_pkg::MAX_TASKS_DEF];
  int                             tbl_used = 0;

  reply_t reply_q[$];
  reply_t step_replies[$];

  int err_cnt = 0;
  int n_req = 0, n_words = 0, n_runs = 0, n_full = 0, n_range = 0;
  int cycles = 0;
  int burst_left = 0;
  int hold_kicks = 0;
  int hold_seen = 0, hold_left = 0, mode_left = 0, rx_phase = 0;
  rx_mode_e rx_mode = RX_OPEN;

  stim_t dir_tab [DIR_N] = '{
    '{ptsch_pkg::REQ_DISPATCH, 8'h00, 32'd0, 32'd0, 4'd0, 1'b1,
      '{1'b0, 8'h00, 1'b1, ptsch_pkg::STATUS_OK, CNT_W'(0)}},
    '{ptsch_pkg::REQ_DELETE, 8'h00, 32'd0, 32'd0, 4'd15, 1'b1,
      '{1'b0, 8'h00, 1'b1, ptsch_pkg::STATUS_RANGE, CNT_W'(0)}},
    '{ptsch_pkg::REQ_DELETE, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 4'd0, 1'b1,
      '{1'b0, 8'h00, 1'b1, ptsch_pkg::STATUS_RANGE, CNT_W'(0)}},
    '{ptsch_pkg::REQ_TICK, 8'h00, 32'd0, 32'd0, 4'd0, 1'b1,
      '{1'b0, 8'h00, 1'b1, ptsch_pkg::STATUS_OK, CNT_W'(0)}},
    '{REQ_RSVD_HI, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 4'd15, 1'b1,
      '{1'b0, 8'h00, 1'b1, ptsch_pkg::STATUS_OK, CNT_W'(0)}},
    '{ptsch_pkg::REQ_CLEAR, 8'h00, 32'd0, 32'd0, 4'd0, 1'b1,
      '{1'b0, 8'h00, 1'b1, ptsch_pkg::STATUS_OK, CNT_W'(0)}},
    // one-shot task due on the first tick
    '{ptsch_pkg::REQ_ADD, 8'h00, 32'd0, 32'd0, 4'd0, 1'b1,
      '{1'b0, 8'h00, 1'b1, ptsch_pkg::STATUS_OK, CNT_W'(1)}},
    '{ptsch_pkg::REQ_ADD, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 4'd15, 1'b1,
      '{1'b0, 8'h00, 1'b1, ptsch_pkg::STATUS_OK, CNT_W'(2)}},
    // period under one tick rounds down to one-shot
    '{ptsch_pkg::REQ_ADD, 8'hA5, 32'd9, 32'd9, 4'd0, 1'b1,
      '{1'b0, 8'h00, 1'b1, ptsch_pkg::STATUS_OK, CNT_W'(3)}},
    '{ptsch_pkg::REQ_ADD, 8'h5A, 32'd10, 32'd10, 4'd0, 1'b1,
      '{1'b0, 8'h00, 1'b1, ptsch_pkg::STATUS_OK, CNT_W'(4)}},
    '{ptsch_pkg::REQ_ADD, 8'h3C, 32'd20, 32'd19, 4'd0, 1'b1,
      '{1'b0, 8'h00, 1'b1, ptsch_pkg::STATUS_OK, CNT_W'(5)}},
    '{ptsch_pkg::REQ_TICK, 8'h00, 32'd0, 32'd0, 4'd0, 1'b1,
      '{1'b0, 8'h00, 1'b1, ptsch_pkg::STATUS_OK, CNT_W'(5)}},
    '{ptsch_pkg::REQ_DISPATCH, 8'h00, 32'd0, 32'd0, 4'd0, 1'b0, '0},
    '{ptsch_pkg::REQ_TICK, 8'h00, 32'd0, 32'd0, 4'd0, 1'b0, '0},
    '{ptsch_pkg::REQ_TICK, 8'h00, 32'd0, 32'd0, 4'd0, 1'b0, '0},
    '{ptsch_pkg::REQ_DISPATCH, 8'h00, 32'd0, 32'd0, 4'd0, 1'b0, '0},
    '{ptsch_pkg::REQ_DELETE, 8'h00, 32'd0, 32'd0, 4'd1, 1'b0, '0},
    '{ptsch_pkg::REQ_DELETE, 8'h00, 32'd0, 32'd0, 4'd14, 1'b0, '0},
    '{REQ_RSVD_LO, 8'h00, 32'd0, 32'd0, 4'd0, 1'b0, '0},
    '{REQ_RSVD_MID, 8'h00, 32'd0, 32'd0, 4'd0, 1'b0, '0},
    '{ptsch_pkg::REQ_DISPATCH, 8'h00, 32'd0, 32'd0, 4'd0, 1'b0, '0},
    '{ptsch_pkg::REQ_CLEAR, 8'h00, 32'd0, 32'd0, 4'd0, 1'b1,
      '{1'b0, 8'h00, 1'b1, ptsch_pkg::STATUS_OK, CNT_W'(0)}},
    '{ptsch_pkg::REQ_DISPATCH, 8'h00, 32'd0, 32'd0, 4'd0, 1'b1,
      '{1'b0, 8'h00, 1'b1, ptsch_pkg::STATUS_OK, CNT_W'(0)}}
  };

  periodic_task_scheduler_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .task_handle_i (task_handle_i),
    .delay_ms_i    (delay_ms_i),
    .period_ms_i   (period_ms_i),
    .task_index_i  (task_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .run_valid_o   (run_valid_o),
    .run_handle_o  (run_handle_o),
    .last_o        (last_o),
    .status_o      (status_o),
    .task_count_o  (task_count_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic stim_t mk(input logic [ptsch_pkg::REQ_W-1:0]    req,
                               input logic [ptsch_pkg::HANDLE_W-1:0] handle,
                               input logic [ptsch_pkg::MS_W-1:0]     delay,
                               input logic [ptsch_pkg::MS_W-1:0]     period,
                               input logic [ptsch_pkg::IDX_W-1:0]    index);
    stim_t s;
    s = '0;
    s.req    = req;
    s.handle = handle;
    s.delay  = delay;
    s.period = period;
    s.index  = index;
    return s;
  endfunction

  // remove a slot and pack the later tasks down
  task automatic drop_slot(input int pos);
    int k;
    for (k = pos; k + 1 < tbl_used; k++) begin
      tbl_handle[k] = tbl_handle[k + 1];
      tbl_delay[k]  = tbl_delay[k + 1];
      tbl_period[k] = tbl_period[k + 1];
      tbl_runs[k]   = tbl_runs[k + 1];
    end
    tbl_used--;
  endtask

  // advance the shadow table by one request and build its reply words
  task automatic sched_apply(input stim_t s);
    logic [ptsch_pkg::STATUS_W-1:0] st;
    reply_t w;
    int i;
    st = ptsch_pkg::STATUS_OK;
    step_replies.delete();
    case (s.req)
      ptsch_pkg::REQ_ADD: begin
        if (tbl_used < ptsch_pkg::MAX_TASKS_DEF) begin
          tbl_handle[tbl_used] = s.handle;
          tbl_delay[tbl_used]  = s.delay / ptsch_pkg::TICK_MS_DEF;
          tbl_period[tbl_used] = s.period / ptsch_pkg::TICK_MS_DEF;
          tbl_runs[tbl_used]   = '0;
          tbl_used++;
        end else begin
          st = ptsch_pkg::STATUS_FULL;
        end
      end
      ptsch_pkg::REQ_TICK: begin
        for (i = 0; i < tbl_used; i++) begin
          if (tbl_delay[i] != 0) begin
            tbl_delay[i]--;
          end else begin
            tbl_delay[i] = tbl_period[i];
            if (tbl_runs[i] != ptsch_pkg::RUNS_MAX) tbl_runs[i]++;
          end
        end
      end
      ptsch_pkg::REQ_DISPATCH: begin
        i = 0;
        while (i < tbl_used) begin
          if (tbl_runs[i] != 0) begin
            tbl_runs[i]--;
            w = '0;
            w.run_valid  = 1'b1;
            w.run_handle = tbl_handle[i];
            step_replies.push_back(w);
            // one-shot leaves; the next task slides into this slot
            if (tbl_period[i] == 0) begin
              drop_slot(i);
              continue;
            end
          end
          i++;
        end
      end
      ptsch_pkg::REQ_DELETE: begin
        if (int'(s.index) >= tbl_used) st = ptsch_pkg::STATUS_RANGE;
        else drop_slot(int'(s.index));
      end
      ptsch_pkg::REQ_CLEAR: begin
        tbl_used = 0;
      end
      default: begin
      end
    endcase
    if (st == ptsch_pkg::STATUS_FULL) n_full++;
    if (st == ptsch_pkg::STATUS_RANGE) n_range++;
    if (step_replies.size() == 0) begin
      w = '0;
      w.status = st;
      step_replies.push_back(w);
    end
    step_replies[step_replies.size() - 1].last = 1'b1;
    foreach (step_replies[k]) step_replies[k].count = CNT_W'(tbl_used);
  endtask

  // present one request word, in bursts with random gaps, until accepted
  task automatic offer(input stim_t s);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(3, 0) == 0) ? 60 : $urandom_range(12, 1);
      gap = $urandom_range(6, 0);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    req_type_i    <= s.req;
    task_handle_i <= s.handle;
    delay_ms_i    <= s.delay;
    period_ms_i   <= s.period;
    task_index_i  <= s.index;
    do @(posedge clk_i); while (!in_ready_o);
    n_req++;
    sched_apply(s);
    if (s.typed) reply_q.push_back(s.want);
    else foreach (step_replies[k]) reply_q.push_back(step_replies[k]);
  endtask

  // stop sending until every reply word is back
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (reply_q.size() != 0);
  endtask

  function automatic logic [ptsch_pkg::MS_W-1:0] rand_delay();
    if ($urandom_range(4, 0) == 0) return ptsch_pkg::MS_W'($urandom);
    return ptsch_pkg::MS_W'($urandom_range(60, 0));
  endfunction

  function automatic logic [ptsch_pkg::MS_W-1:0] rand_period();
    int p;
    p = $urandom_range(19, 0);
    if (p < 5) return ptsch_pkg::MS_W'($urandom_range(ptsch_pkg::TICK_MS_DEF - 1, 0));
    if (p < 8) return ptsch_pkg::MS_W'($urandom);
    return ptsch_pkg::MS_W'($urandom_range(50, 10));
  endfunction

  // reply scoreboard and receiver stall pattern
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_words++;
      if (run_valid_o) n_runs++;
      if (reply_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("%0t: unexpected word valid=%0b handle=%02h last=%0b status=%0d count=%0d",
                   $realtime, run_valid_o, run_handle_o, last_o, status_o, task_count_o);
      end else begin
        want = reply_q.pop_front();
        if (run_valid_o !== want.run_valid || run_handle_o !== want.run_handle ||
            last_o !== want.last || status_o !== want.status || task_count_o !== want.count) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("%0t: exp valid=%0b handle=%02h last=%0b status=%0d count=%0d",
                     $realtime, want.run_valid, want.run_handle, want.last, want.status,
                     want.count);
            $display("%0t: got valid=%0b handle=%02h last=%0b status=%0d count=%0d",
                     $realtime, run_valid_o, run_handle_o, last_o, status_o, task_count_o);
          end
        end
      end
    end
    if (hold_kicks != hold_seen) begin
      hold_seen = hold_kicks;
      hold_left = LONG_HOLD;
    end
    if (mode_left == 0) begin
      rx_mode   = rx_mode_e'($urandom_range(3, 0));
      mode_left = $urandom_range(300, 40);
    end
    mode_left--;
    rx_phase++;
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   out_ready_i <= 1'b1;
        RX_COIN:   out_ready_i <= 1'($urandom_range(1, 0));
        RX_SPARSE: out_ready_i <= (rx_phase % 4 == 0);
        default:   out_ready_i <= ($urandom_range(7, 0) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reply words outstanding", cycles, reply_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int k;
    int roll;
    logic [ptsch_pkg::REQ_W-1:0] req;
    logic [ptsch_pkg::IDX_W-1:0] idx;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < DIR_N; k++) offer(dir_tab[k]);
    wait_drain();

    // fill the table past capacity, then a full dispatch burst under a long output stall
    offer(mk(ptsch_pkg::REQ_CLEAR, 8'h00, '0, '0, '0));
    for (k = 0; k < ptsch_pkg::MAX_TASKS_DEF + 2; k++)
      offer(mk(ptsch_pkg::REQ_ADD, ptsch_pkg::HANDLE_W'($urandom_range(255, 0)), '0,
               ptsch_pkg::MS_W'($urandom_range(40, 0)), '0));
    hold_kicks <= hold_kicks + 1;
    offer(mk(ptsch_pkg::REQ_TICK, 8'h00, '0, '0, '0));
    offer(mk(ptsch_pkg::REQ_DISPATCH, 8'h00, '0, '0, '0));
    for (k = 0; k < 8; k++) begin
      offer(mk(ptsch_pkg::REQ_TICK, 8'h00, '0, '0, '0));
      offer(mk(ptsch_pkg::REQ_DISPATCH, 8'h00, '0, '0, '0));
    end
    wait_drain();

    for (k = 0; k < RAND_ITEMS; k++) begin
      if (k != 0 && k % 70 == 0) wait_drain();
      if (k == 90) hold_kicks <= hold_kicks + 1;
      roll = $urandom_range(99, 0);
      if (roll < 30) req = ptsch_pkg::REQ_ADD;
      else if (roll < 62) req = ptsch_pkg::REQ_TICK;
      else if (roll < 82) req = ptsch_pkg::REQ_DISPATCH;
      else if (roll < 92) req = ptsch_pkg::REQ_DELETE;
      else if (roll < 95) req = ptsch_pkg::REQ_CLEAR;
      else req = ptsch_pkg::REQ_W'($urandom_range(REQ_RSVD_HI, REQ_RSVD_LO));
      if (req == ptsch_pkg::REQ_DELETE && tbl_used > 0 && $urandom_range(4, 0) != 0)
        idx = ptsch_pkg::IDX_W'($urandom_range(tbl_used - 1, 0));
      else
        idx = ptsch_pkg::IDX_W'($urandom_range(15, 0));
      offer(mk(req, ptsch_pkg::HANDLE_W'($urandom_range(255, 0)), rand_delay(),
               rand_period(), idx));
    end

    wait_drain();
    repeat (2 * ptsch_pkg::MAX_TASKS_DEF + 8) @(posedge clk_i);
    if (reply_q.size() != 0) begin
      $display("%0d reply words never arrived", reply_q.size());
      err_cnt += reply_q.size();
    end
    $display("covered %0d requests and %0d reply words, %0d of them task runs",
             n_req, n_words, n_runs);
    $display("table-full adds: %0d, out-of-range deletes: %0d, long output stall with full table",
             n_full, n_range);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
